// ===== rtl/ppt_pkg.sv =====
// ============================================================================
// ppt_pkg: shared types and constants for the perceptron trainer
// Sizes, payload structs, register indexes, outcome codes, the control
// group between the trainer and the weight unit, and the arithmetic helpers.
// ============================================================================
package ppt_pkg;

    localparam int MAX_FEATURES = 8;
    localparam int MAX_SAMPLES  = 256;
    localparam int FPOS_W       = $clog2(MAX_FEATURES);
    localparam int SIDX_W       = $clog2(MAX_SAMPLES);
    localparam int SCNT_W       = SIDX_W + 1;
    localparam int ADDR_W       = SIDX_W + FPOS_W;

    localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [1:0] REG_FEATURE_COUNT = 2'd1;
    localparam logic [1:0] REG_EPOCH_LIMIT   = 2'd2;

    localparam logic [1:0] OUTCOME_CONVERGED = 2'd0;
    localparam logic [1:0] OUTCOME_LIMIT     = 2'd1;
    localparam logic [1:0] OUTCOME_DROPPED   = 2'd2;

    typedef struct packed {
        logic signed [15:0] feature_value;
        logic               class_positive;
        logic               end_of_set;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] weight_value;
        logic [3:0]         weight_slot;
        logic [1:0]         outcome;
        logic [15:0]        epochs_run;
        logic               last_result;
    } out_item_t;

    // Commands from the sequencer to the weight unit
    typedef struct packed {
        logic              clear;      // zero weights and bias
        logic              acc_start;  // load accumulator with bias << 8
        logic              acc_mac;    // accumulate w[idx] * x
        logic              upd_w;      // update w[idx] with step of x
        logic              upd_b;      // update bias
        logic              pos;        // label of the current sample
        logic [FPOS_W-1:0] idx;
    } wu_ctrl_t;

    function automatic logic signed [31:0] clamp32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/ppt_weight_unit.sv =====
// ============================================================================
// ppt_weight_unit: weights, bias and the shared multiply-accumulate unit
// One 32x16 multiplier serves the dot product and the weight step in turn.
// The product is registered before it reaches the accumulator or a weight.
// ============================================================================
module ppt_weight_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ppt_pkg::wu_ctrl_t               ctrl,
    input  logic signed [15:0]              x,
    input  logic [15:0]                     rate,
    input  logic [ppt_pkg::FPOS_W-1:0]      rd_idx,
    input  logic                            rd_bias,
    output logic signed [31:0]              rd_value,
    output logic                            acc_wrong
);
    logic signed [31:0] w_reg [ppt_pkg::MAX_FEATURES];
    logic signed [31:0] w_next [ppt_pkg::MAX_FEATURES];
    logic signed [31:0] b_reg, b_next;
    logic signed [52:0] acc_reg, acc_next;
    logic signed [47:0] prod_reg, prod_next;
    logic               pmac_reg, pupd_reg, ppos_reg;
    logic [ppt_pkg::FPOS_W-1:0] pidx_reg;
    logic signed [32:0] mul_a;
    logic [31:0]        mag;
    logic signed [33:0] step, wsum, bsum;
    logic [47:0]        pabs;

    // Operand select: weight for dot product, rate for step
    always_comb begin
        mul_a     = ctrl.acc_mac ? {w_reg[ctrl.idx][31], w_reg[ctrl.idx]}
                                 : {17'd0, rate};
        prod_next = 48'(mul_a * x);
    end

    always_comb begin
        pabs = prod_reg[47] ? 48'(-prod_reg) : prod_reg;
        mag  = 32'((pabs + 48'd128) >> 8);
        step = (prod_reg[47] ^ ~ppos_reg) ? -34'(mag) : 34'(mag);
        wsum = 34'(w_reg[pidx_reg]) + step;
        bsum = ppos_reg ? 34'(b_reg) + 34'(rate) : 34'(b_reg) - 34'(rate);
    end

    always_comb begin
        w_next   = w_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        if (ctrl.clear) begin
            for (int i = 0; i < ppt_pkg::MAX_FEATURES; i++) begin
                w_next[i] = '0;
            end
            b_next = '0;
        end else begin
            if (pupd_reg) begin
                w_next[pidx_reg] = ppt_pkg::clamp32(wsum);
            end
            if (ctrl.upd_b) begin
                b_next = ppt_pkg::clamp32(bsum);
            end
        end
        if (ctrl.acc_start) begin
            acc_next = 53'(b_reg) <<< 8;
        end else if (pmac_reg) begin
            acc_next = acc_reg + 53'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ppt_pkg::MAX_FEATURES; i++) begin
                w_reg[i] <= '0;
            end
            b_reg    <= '0;
            pmac_reg <= 1'b0;
            pupd_reg <= 1'b0;
        end else begin
            w_reg    <= w_next;
            b_reg    <= b_next;
            pmac_reg <= ctrl.acc_mac;
            pupd_reg <= ctrl.upd_w;
        end
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        ppos_reg <= ctrl.pos;
        pidx_reg <= ctrl.idx;
    end

    assign rd_value  = rd_bias ? b_reg : w_reg[rd_idx];
    assign acc_wrong = ctrl.pos ? (acc_reg <= 0) : (acc_reg >= 0);

`ifndef SYNTHESIS
    a_no_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.acc_mac && ctrl.upd_w)) else $error("mac and update together");
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |=> b_reg == 0) else $error("bias not cleared");
    a_upd_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.upd_w |=> pupd_reg) else $error("update lost");
`endif
endmodule

// ===== rtl/perceptron_primal_trainer.sv =====
// The end_of_set item starts training: a zero fill of the last row, then epochs
//   over the stored samples with an update of every weight and the bias for each
//   misclassified sample, then F+1 results, one per cycle while m_ready is high.
// Throughput: one item per cycle while loading; not ready while training.
// Reset (aresetn, synchronous, active low): weights, bias, counts cleared,
//   registers to defaults; the sample RAM is not cleared (never read unwritten).
// ============================================================================
// perceptron_primal_trainer: primal perceptron trainer, top level
// Sample store, load logic and the training sequencer; the arithmetic
// lives in ppt_weight_unit.
// ============================================================================
module perceptron_primal_trainer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ppt_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ppt_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    localparam int FW = ppt_pkg::FPOS_W;
    localparam int SW = ppt_pkg::SCNT_W;

    // Sequencer states
    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;   // zero-fill tail of last row
    localparam logic [3:0] ST_EPOCH = 4'd2;
    localparam logic [3:0] ST_SAMP  = 4'd3;   // start sample: read label
    localparam logic [3:0] ST_DOT   = 4'd4;   // read feature, mac
    localparam logic [3:0] ST_DRAIN = 4'd5;   // wait for products
    localparam logic [3:0] ST_DEC   = 4'd6;
    localparam logic [3:0] ST_UPD   = 4'd7;
    localparam logic [3:0] ST_UDRN  = 4'd8;
    localparam logic [3:0] ST_NEXT  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [15:0] rate_reg, limit_reg;
    logic [3:0]  fcount_reg;
    logic [3:0]  state_reg, state_next;
    logic [SW-1:0] nsamp_reg, nsamp_next, sidx_reg, sidx_next;
    logic [FW-1:0] fpos_reg, fpos_next, j_reg, j_next;
    logic          ovf_reg, ovf_next, chg_reg, chg_next, pos_reg, pos_next;
    logic [1:0]    drn_reg, drn_next;
    logic [15:0]   ep_reg, ep_next;
    logic [3:0]    oslot_reg, oslot_next;
    logic          mval_reg, mval_next;
    ppt_pkg::out_item_t mdat_reg, mdat_next;

    logic signed [15:0] smem [ppt_pkg::MAX_SAMPLES*ppt_pkg::MAX_FEATURES];
    logic               lmem [ppt_pkg::MAX_SAMPLES];
    logic [FW-1:0]      lenmem [ppt_pkg::MAX_SAMPLES];
    logic signed [15:0] x_rd;
    logic               l_rd;
    logic [FW-1:0]      len_rd;
    logic signed [15:0] x_use;
    logic               we, lwe;
    logic [ppt_pkg::ADDR_W-1:0] waddr, raddr;
    logic signed [15:0] wdata;
    logic [ppt_pkg::SIDX_W-1:0] lwaddr;

    ppt_pkg::wu_ctrl_t  ctrl;
    logic signed [31:0] rd_value;
    logic               acc_wrong;
    logic [3:0]         nf;
    logic [FW-1:0]      nf_last;
    logic               closes, s_fire, m_fire;
    logic [15:0]        limit_eff;

    assign nf = (fcount_reg == 4'd0) ? 4'd1 :
                (fcount_reg > 4'(ppt_pkg::MAX_FEATURES)) ? 4'(ppt_pkg::MAX_FEATURES)
                                                         : fcount_reg;
    assign nf_last   = FW'(nf - 4'd1);
    assign limit_eff = (limit_reg == 16'd0) ? 16'd1 : limit_reg;
    assign s_ready   = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = mval_reg && m_ready;
    assign m_valid   = mval_reg;
    assign m_data    = mdat_reg;
    assign closes    = s_data.end_of_set || (4'(fpos_reg) + 4'd1 >= nf);
    // Features past the written length of a row read as zero
    assign x_use     = (j_reg > len_rd) ? 16'sd0 : x_rd;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= 16'hFFFF;
            fcount_reg <= 4'd8;
            limit_reg  <= 16'd1000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ppt_pkg::REG_LEARNING_RATE: rate_reg   <= cfg_data;
                ppt_pkg::REG_FEATURE_COUNT: fcount_reg <= cfg_data[3:0];
                ppt_pkg::REG_EPOCH_LIMIT:   limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sample, label and row length memories; one write, one registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            smem[waddr] <= wdata;
        end
        if (lwe) begin
            lmem[lwaddr]   <= s_data.class_positive;
            lenmem[lwaddr] <= fpos_reg;
        end
        x_rd   <= smem[raddr];
        l_rd   <= lmem[sidx_reg[ppt_pkg::SIDX_W-1:0]];
        len_rd <= lenmem[sidx_reg[ppt_pkg::SIDX_W-1:0]];
    end

    always_comb begin
        state_next = state_reg;
        nsamp_next = nsamp_reg;
        sidx_next  = sidx_reg;
        fpos_next  = fpos_reg;
        j_next     = j_reg;
        ovf_next   = ovf_reg;
        chg_next   = chg_reg;
        pos_next   = pos_reg;
        drn_next   = drn_reg;
        ep_next    = ep_reg;
        oslot_next = oslot_reg;
        mval_next  = mval_reg;
        mdat_next  = mdat_reg;
        we     = 1'b0;
        lwe    = 1'b0;
        waddr  = {nsamp_reg[ppt_pkg::SIDX_W-1:0], fpos_reg};
        wdata  = s_data.feature_value;
        lwaddr = nsamp_reg[ppt_pkg::SIDX_W-1:0];
        raddr  = {sidx_reg[ppt_pkg::SIDX_W-1:0], j_reg};
        ctrl   = '0;
        ctrl.pos = pos_reg;
        ctrl.idx = j_reg;
        if (m_fire) begin
            mval_next = 1'b0;
        end
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (nsamp_reg < SW'(ppt_pkg::MAX_SAMPLES)) begin
                        we = 1'b1;
                        if (closes) begin
                            lwe = 1'b1;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    fpos_next = closes ? '0 : fpos_reg + FW'(1);
                    if (s_data.end_of_set) begin
                        j_next = fpos_reg;
                        ctrl.clear = 1'b1;
                        ep_next = '0;
                        state_next = (nsamp_reg < SW'(ppt_pkg::MAX_SAMPLES))
                                     ? ST_FILL : ST_EPOCH;
                    end else if (closes && nsamp_reg < SW'(ppt_pkg::MAX_SAMPLES)) begin
                        nsamp_next = nsamp_reg + SW'(1);
                    end
                end
            end
            ST_FILL: begin
                // Zero the unused tail of the final sample, then count it
                if (4'(j_reg) + 4'd1 >= 4'(ppt_pkg::MAX_FEATURES)) begin
                    nsamp_next = nsamp_reg + SW'(1);
                    state_next = ST_EPOCH;
                end else begin
                    j_next = j_reg + FW'(1);
                    we     = 1'b1;
                    waddr  = {nsamp_reg[ppt_pkg::SIDX_W-1:0], FW'(j_reg + FW'(1))};
                    wdata  = '0;
                end
            end
            ST_EPOCH: begin
                sidx_next  = '0;
                chg_next   = 1'b0;
                ep_next    = ep_reg + 16'd1;
                state_next = (nsamp_reg == '0) ? ST_NEXT : ST_SAMP;
                j_next     = '0;
            end
            ST_SAMP: begin
                // Memory read of feature 0 and label now in flight
                ctrl.acc_start = 1'b1;
                state_next = ST_DOT;
            end
            ST_DOT: begin
                pos_next     = l_rd;
                ctrl.acc_mac = 1'b1;
                ctrl.pos     = l_rd;
                ctrl.idx     = j_reg;
                // x_rd holds feature j_reg; product registered next cycle
                if (j_reg == nf_last) begin
                    drn_next   = 2'd2;
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + FW'(1);
                    raddr  = {sidx_reg[ppt_pkg::SIDX_W-1:0], FW'(j_reg + FW'(1))};
                end
            end
            ST_DRAIN: begin
                if (drn_reg == 2'd0) begin
                    state_next = ST_DEC;
                end else begin
                    drn_next = drn_reg - 2'd1;
                end
                j_next = '0;
                raddr  = {sidx_reg[ppt_pkg::SIDX_W-1:0], FW'(0)};
            end
            ST_DEC: begin
                if (acc_wrong) begin
                    chg_next   = 1'b1;
                    state_next = ST_UPD;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_UPD: begin
                ctrl.upd_w = 1'b1;
                if (j_reg == nf_last) begin
                    ctrl.upd_b = 1'b1;
                    drn_next   = 2'd1;
                    state_next = ST_UDRN;
                end else begin
                    j_next = j_reg + FW'(1);
                    raddr  = {sidx_reg[ppt_pkg::SIDX_W-1:0], FW'(j_reg + FW'(1))};
                end
            end
            ST_UDRN: begin
                if (drn_reg == 2'd0) begin
                    state_next = ST_NEXT;
                end else begin
                    drn_next = drn_reg - 2'd1;
                end
            end
            ST_NEXT: begin
                j_next = '0;
                if (sidx_reg + SW'(1) < nsamp_reg) begin
                    sidx_next  = sidx_reg + SW'(1);
                    raddr      = {FW'(0)} | ppt_pkg::ADDR_W'({sidx_reg + SW'(1), FW'(0)});
                    state_next = ST_SAMP;
                end else if (chg_reg && ep_reg < limit_eff) begin
                    sidx_next  = '0;
                    state_next = ST_EPOCH;
                end else begin
                    oslot_next = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mval_reg || m_fire) begin
                    mval_next = 1'b1;
                    mdat_next.weight_value = rd_value;
                    mdat_next.weight_slot  = oslot_reg;
                    mdat_next.outcome = ovf_reg ? ppt_pkg::OUTCOME_DROPPED :
                                        chg_reg ? ppt_pkg::OUTCOME_LIMIT
                                                : ppt_pkg::OUTCOME_CONVERGED;
                    mdat_next.epochs_run  = ep_reg;
                    mdat_next.last_result = (oslot_reg == nf);
                    if (oslot_reg == nf) begin
                        nsamp_next = '0;
                        fpos_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        oslot_next = oslot_reg + 4'd1;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            nsamp_reg <= '0;
            fpos_reg  <= '0;
            ovf_reg   <= 1'b0;
            mval_reg  <= 1'b0;
            sidx_reg  <= '0;
            j_reg     <= '0;
            chg_reg   <= 1'b0;
            drn_reg   <= '0;
            ep_reg    <= '0;
            oslot_reg <= '0;
        end else begin
            state_reg <= state_next;
            nsamp_reg <= nsamp_next;
            fpos_reg  <= (fpos_next >= FW'(ppt_pkg::MAX_FEATURES - 1) && 4'(fpos_next) >= nf)
                         ? '0 : fpos_next;
            ovf_reg   <= ovf_next;
            mval_reg  <= mval_next;
            sidx_reg  <= sidx_next;
            j_reg     <= j_next;
            chg_reg   <= chg_next;
            drn_reg   <= drn_next;
            ep_reg    <= ep_next;
            oslot_reg <= oslot_next;
        end
        pos_reg  <= pos_next;
        mdat_reg <= mdat_next;
    end

    ppt_weight_unit u_wu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .x         (x_use),
        .rate      (rate_reg),
        .rd_idx    (oslot_reg[FW-1:0]),
        .rd_bias   (oslot_reg == nf),
        .rd_value  (rd_value),
        .acc_wrong (acc_wrong)
    );

`ifndef SYNTHESIS
    a_ready_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_LOAD) else $error("ready outside load");
    a_nsamp_max: assert property (@(posedge aclk) disable iff (!aresetn)
        nsamp_reg <= SW'(ppt_pkg::MAX_SAMPLES)) else $error("sample count overflow");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mval_reg && !m_ready) |=> mval_reg) else $error("result dropped");
`endif
endmodule

// ===== tb/perceptron_primal_trainer_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// perceptron_primal_trainer_tb: self-checking bench for the perceptron trainer
// Streams labelled data sets through the input channel, trains a local copy of
// the primal perceptron on each set of accepted items, and checks every emitted
// weight and bias against it while both channels idle and stall at random.
// ============================================================================
module perceptron_primal_trainer_tb;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    ppt_pkg::in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    ppt_pkg::out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    perceptron_primal_trainer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local trainer state: store, weights, counters and register copies
    shortint   sample_mem [ppt_pkg::MAX_SAMPLES][ppt_pkg::MAX_FEATURES];
    bit        label_mem [ppt_pkg::MAX_SAMPLES];
    int        weights [ppt_pkg::MAX_FEATURES];
    int        bias;
    int        rows_loaded;
    int        feat_pos;
    bit        dropped;
    int        eta = 65535;
    int        feat_cnt = 8;
    int        max_epochs = 1000;

    ppt_pkg::out_item_t weight_q[$];     // trained weights still owed by the block
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        recv_hold = 0;   // cycles the receiver still holds off
    int        items_sent = 0;
    int        sets_trained = 0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Runaway guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, weight_q.size());
            $display("perceptron_primal_trainer verification failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off when requested
    always @(posedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest trained weight
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (weight_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) begin
                    $display("unexpected result %p", m_data);
                end
            end else if (m_data !== weight_q[0]) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) begin
                    $display("mismatch: expected %p, got %p", weight_q[0], m_data);
                end
                void'(weight_q.pop_front());
            end else begin
                void'(weight_q.pop_front());
            end
        end
    end

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    // Q7.24 step rounded half away from zero to Q15.16
    function automatic longint step_of(shortint x);
        longint p;
        p = longint'(eta) * longint'(x);
        if (p >= 0) return (p + 128) >>> 8;
        return -((-p + 128) >>> 8);
    endfunction

    // One pass over the stored rows; report whether any sample was misclassified
    function automatic bit train_pass(int nf);
        bit     moved;
        bit     pos;
        longint acc;
        moved = 1'b0;
        for (int s = 0; s < rows_loaded; s++) begin
            pos = label_mem[s];
            acc = longint'(bias) * 256;
            for (int j = 0; j < nf; j++) begin
                acc += longint'(weights[j]) * longint'(sample_mem[s][j]);
            end
            if (pos ? (acc <= 0) : (acc >= 0)) begin
                for (int j = 0; j < nf; j++) begin
                    weights[j] = sat32(longint'(weights[j]) +
                                       (pos ? step_of(sample_mem[s][j])
                                            : -step_of(sample_mem[s][j])));
                end
                bias  = sat32(longint'(bias) + (pos ? longint'(eta) : -longint'(eta)));
                moved = 1'b1;
            end
        end
        return moved;
    endfunction

    // Absorb one accepted item; on end of set train and queue the weights
    task automatic absorb_item(ppt_pkg::in_item_t it);
        int        nf;
        bit        closes;
        bit        moved;
        int        lim;
        int        epochs;
        ppt_pkg::out_item_t r;
        nf = (feat_cnt == 0) ? 1 : ((feat_cnt > ppt_pkg::MAX_FEATURES) ?
                                    ppt_pkg::MAX_FEATURES : feat_cnt);
        if (feat_pos >= ppt_pkg::MAX_FEATURES) feat_pos = 0;
        closes = it.end_of_set || (feat_pos + 1 >= nf);
        if (rows_loaded < ppt_pkg::MAX_SAMPLES) begin
            sample_mem[rows_loaded][feat_pos] = it.feature_value;
            if (closes) begin
                for (int j = feat_pos + 1; j < ppt_pkg::MAX_FEATURES; j++) begin
                    sample_mem[rows_loaded][j] = 0;
                end
                label_mem[rows_loaded] = it.class_positive;
                rows_loaded++;
            end
        end else begin
            dropped = 1'b1;
        end
        feat_pos = closes ? 0 : feat_pos + 1;
        if (!it.end_of_set) return;

        foreach (weights[j]) weights[j] = 0;
        bias   = 0;
        lim    = (max_epochs == 0) ? 1 : max_epochs;
        epochs = 0;
        moved  = 1'b1;
        while (moved && epochs < lim) begin
            moved = train_pass(nf);
            epochs++;
        end
        for (int j = 0; j <= nf; j++) begin
            r.weight_value = (j < nf) ? weights[j] : bias;
            r.weight_slot  = 4'(j);
            r.outcome      = dropped ? ppt_pkg::OUTCOME_DROPPED :
                             (moved ? ppt_pkg::OUTCOME_LIMIT : ppt_pkg::OUTCOME_CONVERGED);
            r.epochs_run   = 16'(epochs);
            r.last_result  = (j == nf);
            weight_q.push_back(r);
        end
        rows_loaded = 0;
        feat_pos    = 0;
        dropped     = 1'b0;
        sets_trained++;
    endtask

    // Offer one item, hold it until accepted, then absorb it into the local copy
    task automatic send_item(logic signed [15:0] x, bit label, bit eos);
        ppt_pkg::in_item_t it;
        it.feature_value  = x;
        it.class_positive = label;
        it.end_of_set     = eos;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        absorb_item(it);
    endtask

    // Drop valid and wait until every owed weight has come, plus a margin
    task automatic drain();
        s_valid <= 1'b0;
        while (weight_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            ppt_pkg::REG_LEARNING_RATE: eta = val;
            ppt_pkg::REG_FEATURE_COUNT: feat_cnt = val[3:0];
            ppt_pkg::REG_EPOCH_LIMIT:   max_epochs = val;
            default: ;
        endcase
    endtask

    task automatic setup(int rate, int nf, int lim);
        drain();
        write_reg(ppt_pkg::REG_LEARNING_RATE, 16'(rate));
        write_reg(ppt_pkg::REG_FEATURE_COUNT, 16'(nf));
        write_reg(ppt_pkg::REG_EPOCH_LIMIT, 16'(lim));
    endtask

    function automatic logic signed [15:0] rand_feature();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'(signed'($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Send a set of whole samples; a broken set cuts its last sample short
    task automatic send_set(int rows, int nf, bit broken);
        logic signed [15:0] x [ppt_pkg::MAX_FEATURES];
        int  len;
        bit  label;
        int  flip;
        flip = $urandom_range(1);
        for (int s = 0; s < rows; s++) begin
            foreach (x[j]) x[j] = rand_feature();
            // mostly separable labels, some pure noise
            label = ($urandom_range(9) < 7) ? ((x[0] > 0) ^ flip[0]) : $urandom_range(1);
            len   = (broken && s == rows - 1 && nf > 1) ? $urandom_range(nf - 1, 1) : nf;
            for (int j = 0; j < len; j++) begin
                send_item(x[j], label, (s == rows - 1) && (j == len - 1));
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Extremes of features, labels, rates, counts and epoch limits
    task automatic test_directed();
        setup(65535, 8, 65535);
        send_item(16'sh7FFF, 1'b1, 1'b0);
        for (int j = 1; j < 7; j++) send_item(16'sh8000, 1'b1, 1'b0);
        send_item(16'sh0001, 1'b1, 1'b1);
        setup(1, 1, 1);
        send_item(16'sh8000, 1'b0, 1'b0);
        send_item(16'sh7FFF, 1'b1, 1'b1);
        // zero rate on a misclassified set runs to the limit
        setup(0, 2, 3);
        send_item(16'sh0100, 1'b1, 1'b0);
        send_item(16'sh0100, 1'b1, 1'b1);
        // count zero acts as one, count above the maximum acts as the maximum
        setup(40000, 0, 5);
        send_item(16'shFF00, 1'b0, 1'b1);
        setup(40000, 15, 0);
        send_item(16'sh1234, 1'b0, 1'b0);
        send_item(16'sh4321, 1'b1, 1'b1);
        // a set of one zero item that closes the set at once
        setup(65535, 3, 1);
        send_item(16'sh0000, 1'b1, 1'b1);
        // shrink the count mid-sample: the next item closes the sample
        setup(30000, 8, 50);
        send_item(16'sh0200, 1'b1, 1'b0);
        send_item(16'sh0300, 1'b1, 1'b0);
        send_item(16'shFD00, 1'b1, 1'b0);
        drain();
        write_reg(ppt_pkg::REG_FEATURE_COUNT, 16'd2);
        send_item(16'sh0100, 1'b0, 1'b0);
        send_item(16'shFF00, 1'b0, 1'b1);
    endtask

    // Fill the sample store and overrun it
    task automatic test_store_overflow();
        setup(20000, 1, 2);
        for (int s = 0; s < ppt_pkg::MAX_SAMPLES + 3; s++) begin
            send_item(rand_feature(), $urandom_range(1), s == ppt_pkg::MAX_SAMPLES + 2);
        end
    endtask

    // Random sets under one idling pattern
    task automatic test_random_sets(int snd, int rcv, int budget);
        int stop;
        int nf;
        drain();
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        stop = items_sent + budget;
        while (items_sent < stop) begin
            nf = $urandom_range(8, 1);
            setup($urandom_range(3) == 0 ? 65535 : $urandom_range(65535, 1), nf,
                  $urandom_range(4) == 0 ? 300 : $urandom_range(20, 1));
            send_set($urandom_range(5, 1), nf, $urandom_range(9) == 0);
        end
    endtask

    // Hold the receiver off while sets keep coming, then wait it out
    task automatic test_backpressure();
        setup(65535, 2, 4);
        recv_idle_pct = 0;
        send_idle_pct = 0;
        recv_hold     = 400;
        for (int k = 0; k < 4; k++) send_set(2, 2, 1'b0);
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_store_overflow();
        test_random_sets(15, 83, 35);
        test_random_sets(83, 15, 35);
        test_random_sets(0, 0, 35);
        drain();
        repeat (50) @(posedge aclk);

        $display("%0d items sent, %0d data sets trained, %0d weights checked",
                 items_sent, sets_trained, results_seen);
        $display("covered extreme rates, counts and limits, store overrun, long stalls");
        if (mismatches == 0 && weight_q.size() == 0) begin
            $display("perceptron_primal_trainer verification clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, weight_q.size());
            $display("perceptron_primal_trainer verification failed");
        end
        $finish;
    end

endmodule
